/* rtl/wrms_pkg.sv */
// shared types and constants for the weighted rank minimum selector
// used by wrms_rank and weighted_rank_min_select_top, no dependencies
package wrms_pkg;

  localparam int unsigned PRI_W       = 8;
  localparam int unsigned TIME_W      = 16;
  localparam int unsigned WEIGHT_W    = 8;
  localparam int unsigned PPRI_W      = PRI_W + WEIGHT_W;
  localparam int unsigned PTIME_W     = TIME_W + WEIGHT_W;
  localparam int unsigned RANK_W      = 25;
  localparam int unsigned INDEX_W     = 6;
  localparam int unsigned QUOT_W      = 21;
  localparam int unsigned RECIP_W     = 24;
  localparam int unsigned RECIP_SHIFT = 27;
  localparam int unsigned RPROD_W     = PTIME_W + RECIP_W;

  // ceil(2^27 / 10), exact floor divide by ten for inputs below 2^26
  localparam logic [RECIP_W-1:0] DIV10_RECIP = 24'hCCCCCD;

  typedef struct packed {
    logic                runnable;
    logic [PRI_W-1:0]    priority_req;
    logic [TIME_W-1:0]   arrival_time;
    logic [TIME_W-1:0]   exec_tenths;
    logic [WEIGHT_W-1:0] priority_weight;
    logic [WEIGHT_W-1:0] arrival_weight;
    logic [WEIGHT_W-1:0] exec_weight;
    logic                last_entry;
  } wrms_entry_t;

  typedef struct packed {
    logic runnable;
    logic last_entry;
  } wrms_tag_t;

endpackage

/* rtl/weighted_rank_min_select_top.sv */
// top level of the weighted rank minimum selector: running minimum and result word
// depends on wrms_pkg and wrms_rank
//
// usage
//   the slave stream takes one task entry per word; tlast marks the last entry
//   of a table scan. each runnable entry gets
//   rank = priority*w1 + arrival*w2 + floor(exec_tenths*w3/10)
//   and the lowest rank wins, the earliest entry on ties. the last entry of a
//   scan produces one master word with the winning position, a found flag and
//   the rank; with nothing runnable all three are zero.
//   throughput is one entry per cycle unless a last entry waits on a stalled
//   master side; the master word follows the last entry through the input,
//   product and quotient registers into the result register.
//   reset clears the pipeline, the running minimum and the entry position.
//   a stalled master side holds its word; entries keep flowing into the
//   datapath and the running minimum, and only a second last entry waits at
//   the final stage, filling the pipeline before tready drops.
module weighted_rank_min_select_top #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // runnable, priority_req, arrival_time, exec_tenths, priority_weight,
  // arrival_weight, exec_weight, zero pad
  input  logic [71:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // chosen_index, found, best_rank
  output logic [31:0] m_axis_tdata_o
);
  import wrms_pkg::*;

  localparam int unsigned POS_W = $clog2(ENTRIES);

  wrms_entry_t          entry;
  wrms_tag_t            tag;
  logic                 rank_valid, rank_ready, fire;
  logic [RANK_W-1:0]    psum;
  logic [QUOT_W-1:0]    quot;
  logic [RANK_W-1:0]    rank;
  logic                 take;
  logic                 out_free;

  logic [RANK_W-1:0]    low_rank_d, low_rank_q;
  logic [POS_W-1:0]     low_idx_d, low_idx_q;
  logic [POS_W-1:0]     pos_d, pos_q;
  logic                 any_d, any_q;

  logic                 out_v_d, out_v_q;
  logic [INDEX_W-1:0]   out_idx_d, out_idx_q;
  logic                 out_found_d, out_found_q;
  logic [RANK_W-1:0]    out_rank_d, out_rank_q;
  logic [INDEX_W+POS_W-1:0] idx_wide;

  assign entry.runnable        = s_axis_tdata_i[0];
  assign entry.priority_req    = s_axis_tdata_i[8:1];
  assign entry.arrival_time    = s_axis_tdata_i[24:9];
  assign entry.exec_tenths     = s_axis_tdata_i[40:25];
  assign entry.priority_weight = s_axis_tdata_i[48:41];
  assign entry.arrival_weight  = s_axis_tdata_i[56:49];
  assign entry.exec_weight     = s_axis_tdata_i[64:57];
  assign entry.last_entry      = s_axis_tlast_i;

  wrms_rank u_rank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .entry_i (entry),
    .valid_o (rank_valid),
    .ready_i (rank_ready),
    .tag_o   (tag),
    .psum_o  (psum),
    .quot_o  (quot)
  );

  assign out_free   = !out_v_q || m_axis_tready_i;
  assign rank_ready = !tag.last_entry || out_free;
  assign fire       = rank_valid && rank_ready;
  assign rank       = psum + RANK_W'(quot);
  assign take       = tag.runnable && (!any_q || (rank < low_rank_q));

  always_comb begin
    low_rank_d  = low_rank_q;
    low_idx_d   = low_idx_q;
    any_d       = any_q;
    pos_d       = pos_q;
    out_v_d     = out_v_q && !m_axis_tready_i;
    out_idx_d   = out_idx_q;
    out_found_d = out_found_q;
    out_rank_d  = out_rank_q;
    idx_wide    = '0;
    if (fire) begin
      if (take) begin
        low_rank_d = rank;
        low_idx_d  = pos_q;
        any_d      = 1'b1;
      end
      if (tag.last_entry) begin
        idx_wide    = {{INDEX_W{1'b0}}, low_idx_d};
        out_v_d     = 1'b1;
        out_found_d = any_d;
        out_idx_d   = any_d ? idx_wide[INDEX_W-1:0] : '0;
        out_rank_d  = any_d ? low_rank_d : '0;
        low_rank_d  = '0;
        low_idx_d   = '0;
        any_d       = 1'b0;
        pos_d       = '0;
      end else begin
        pos_d = (pos_q == POS_W'(ENTRIES - 1)) ? '0 : pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_rank_q <= '0;
      low_idx_q  <= '0;
      any_q      <= 1'b0;
      pos_q      <= '0;
      out_v_q    <= 1'b0;
    end else begin
      low_rank_q <= low_rank_d;
      low_idx_q  <= low_idx_d;
      any_q      <= any_d;
      pos_q      <= pos_d;
      out_v_q    <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_idx_q   <= out_idx_d;
    out_found_q <= out_found_d;
    out_rank_q  <= out_rank_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_rank_q, out_found_q, out_idx_q};

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(ENTRIES - 1))
    else $error("entry position beyond table size");

  a_scan_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && tag.last_entry |=> pos_q == '0 && !any_q && low_rank_q == '0)
    else $error("scan state not cleared after last entry");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_found_q |-> out_idx_q == '0 && out_rank_q == '0)
    else $error("result without runnable entry is not zero");

  a_idle_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !any_q |-> low_rank_q == '0 && low_idx_q == '0)
    else $error("running minimum set without runnable entry");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rank_valid && tag.last_entry && !out_free |=> rank_valid && tag.last_entry)
    else $error("last entry dropped while result stalled");

endmodule

/* rtl/wrms_rank.sv */
// three stage rank datapath: input register, weight products, partial sum and divide by ten
// depends on wrms_pkg
module wrms_rank (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  wrms_pkg::wrms_entry_t          entry_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output wrms_pkg::wrms_tag_t            tag_o,
  output logic [wrms_pkg::RANK_W-1:0]    psum_o,
  output logic [wrms_pkg::QUOT_W-1:0]    quot_o
);
  import wrms_pkg::*;

  logic                v1_q, v2_q, v3_q;
  logic                ready1, ready2, ready3;
  wrms_entry_t         e1_q;
  wrms_tag_t           tag2_q, tag3_q;
  logic [PPRI_W-1:0]   ppri_d, ppri_q;
  logic [PTIME_W-1:0]  parr_d, parr_q;
  logic [PTIME_W-1:0]  pext_d, pext_q;
  logic [RPROD_W-1:0]  rprod;
  logic [RANK_W-1:0]   psum_d, psum_q;
  logic [QUOT_W-1:0]   quot_d, quot_q;

  assign ready3  = !v3_q || ready_i;
  assign ready2  = !v2_q || ready3;
  assign ready1  = !v1_q || ready2;
  assign ready_o = ready1;

  assign ppri_d = PPRI_W'(e1_q.priority_req) * PPRI_W'(e1_q.priority_weight);
  assign parr_d = PTIME_W'(e1_q.arrival_time) * PTIME_W'(e1_q.arrival_weight);
  assign pext_d = PTIME_W'(e1_q.exec_tenths) * PTIME_W'(e1_q.exec_weight);

  assign rprod  = RPROD_W'(pext_q) * RPROD_W'(DIV10_RECIP);
  assign quot_d = rprod[RECIP_SHIFT +: QUOT_W];
  assign psum_d = RANK_W'(ppri_q) + RANK_W'(parr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= valid_i;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready1) begin
      e1_q <= entry_i;
    end
    if (v1_q && ready2) begin
      ppri_q <= ppri_d;
      parr_q <= parr_d;
      pext_q <= pext_d;
      tag2_q <= '{runnable: e1_q.runnable, last_entry: e1_q.last_entry};
    end
    if (v2_q && ready3) begin
      psum_q <= psum_d;
      quot_q <= quot_d;
      tag3_q <= tag2_q;
    end
  end

  assign valid_o = v3_q;
  assign tag_o   = tag3_q;
  assign psum_o  = psum_q;
  assign quot_o  = quot_q;

endmodule
